// ===== sv/prpf_pkg.sv =====
// Shared types, constants and codes for the polygon region point filter.
package prpf_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int VIDX_W     = 6;
    localparam int COORD_W    = 32;
    localparam int INTEN_W    = 16;
    localparam int COUNT_W    = 7;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W   = 120;
    localparam int OUT_TDATA_W  = 112;
    localparam int OUT_TUSER_W  = 2;

    // 9.0 in Q8.8 and the guard band around it.
    localparam logic [INTEN_W-1:0] NINE_Q88      = 16'd2304;
    localparam logic [INTEN_W-1:0] NEAR_NINE_LSB = 16'd2;

    typedef enum logic
    {
        FUNC_LOAD  = 1'b0,
        FUNC_POINT = 1'b1
    } func_t;

    typedef enum logic [CFG_ADDR_W-1:0]
    {
        REG_VERTEX_COUNT     = 3'd0,
        REG_MIN_Z            = 3'd1,
        REG_MAX_Z            = 3'd2,
        REG_INTENSITY_ENABLE = 3'd3,
        REG_MIN_INTENSITY    = 3'd4,
        REG_MAX_INTENSITY    = 3'd5,
        REG_KEEP_OUTSIDE     = 3'd6
    } cfg_reg_t;

    // One item moving down the cell chain: the input fields, the flags worked
    // out at entry, the running crossing parity and the vertices it carries.
    typedef struct packed
    {
        func_t                      func;
        logic [VIDX_W-1:0]          vidx;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic [INTEN_W-1:0]         inten;
        logic                       zok;
        logic                       rescue;
        logic                       parity;
        logic signed [COORD_W-1:0]  v0x;
        logic signed [COORD_W-1:0]  v0y;
        logic signed [COORD_W-1:0]  prevx;
        logic signed [COORD_W-1:0]  prevy;
    } item_t;

endpackage

// ===== sv/polygon_region_point_filter.sv =====
// Top level of the polygon region point filter: entry flags, cell chain, output register.
//
//  Channel  Direction  Fields (lowest bit first)
//  -------  ---------  ----------------------------------------------------------
//  s_*      in         tuser: func; tdata: vertex_index, point_x, point_y,
//                      point_z, point_intensity, two zero bits
//  m_*      out        tuser: keep, inside_res; tdata: out_x, out_y, out_z,
//                      out_intensity
//  cfg_*    in         write enable, register index, write data
//
// The block takes one transfer per cycle unless the chain is frozen. Each
// item walks a chain of MAX_VERTICES+1 cells, three register stages per cell,
// before a point result is written into the output register.
// Vertex loads travel the same chain and are written into their cell on the
// way, so every point sees exactly the vertices loaded before it.
// Reset clears the control state and the configuration registers at once;
// the vertex store needs no clearing and holds nothing useful until loaded.
// The chain freezes only when a point result reaches its end while the output
// register still holds an untaken result; bubbles and loads keep moving.
module polygon_region_point_filter #(
    parameter int MAX_VERTICES = prpf_pkg::MAX_VERTICES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // func
    input  logic                               s_tuser,
    // vertex_index, point_x, point_y, point_z, point_intensity, zero fill
    input  logic [prpf_pkg::IN_TDATA_W-1:0]    s_tdata,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // keep, inside_res
    output logic [prpf_pkg::OUT_TUSER_W-1:0]   m_tuser,
    // out_x, out_y, out_z, out_intensity
    output logic [prpf_pkg::OUT_TDATA_W-1:0]   m_tdata,

    input  logic                               cfg_wen,
    input  logic [prpf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [prpf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import prpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CHAIN = MAX_VERTICES + 2;

    // Configuration registers.
    logic [COUNT_W-1:0]        count_reg;
    logic signed [COORD_W-1:0] min_z_reg;
    logic signed [COORD_W-1:0] max_z_reg;
    logic                      ien_reg;
    logic [INTEN_W-1:0]        min_i_reg;
    logic [INTEN_W-1:0]        max_i_reg;
    logic                      ko_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_z_reg <= {1'b1, {(COORD_W-1){1'b0}}};
            max_z_reg <= {1'b0, {(COORD_W-1){1'b1}}};
            ien_reg   <= 1'b0;
            min_i_reg <= '0;
            max_i_reg <= '1;
            ko_reg    <= 1'b0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_VERTEX_COUNT:     count_reg <= cfg_wdata[COUNT_W-1:0];
                REG_MIN_Z:            min_z_reg <= cfg_wdata[COORD_W-1:0];
                REG_MAX_Z:            max_z_reg <= cfg_wdata[COORD_W-1:0];
                REG_INTENSITY_ENABLE: ien_reg   <= cfg_wdata[0];
                REG_MIN_INTENSITY:    min_i_reg <= cfg_wdata[INTEN_W-1:0];
                REG_MAX_INTENSITY:    max_i_reg <= cfg_wdata[INTEN_W-1:0];
                REG_KEEP_OUTSIDE:     ko_reg    <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    // Vertices in use, saturated to MAX_VERTICES.
    logic [CNT_W-1:0] n_used;

    always_comb
    begin
        if (32'(count_reg) > MAX_VERTICES)
        begin
            n_used = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_used = CNT_W'(count_reg);
        end
    end

    // The chain: entry at index 0, cell g feeds index g+1, the tail is last.
    logic  chain_valid [0:CHAIN-1];
    item_t chain_item  [0:CHAIN-1];
    logic  advance;

    // Entry: unpack the transfer and settle the Z window and the intensity
    // rescue up front, since neither depends on the polygon.
    item_t entry;

    always_comb
    begin
        entry        = '0;
        entry.func   = func_t'(s_tuser);
        entry.vidx   = s_tdata[5:0];
        entry.px     = s_tdata[37:6];
        entry.py     = s_tdata[69:38];
        entry.pz     = s_tdata[101:70];
        entry.inten  = s_tdata[117:102];
        entry.zok    = (entry.pz >= min_z_reg) && (entry.pz <= max_z_reg);
        // The rescue skips intensities within two steps of 9.0.
        entry.rescue = ien_reg &&
                       (entry.inten >= min_i_reg) && (entry.inten <= max_i_reg) &&
                       (((INTEN_W+1)'(entry.inten) >
                         (INTEN_W+1)'(NINE_Q88) + (INTEN_W+1)'(NEAR_NINE_LSB)) ||
                        ((INTEN_W+1)'(entry.inten) + (INTEN_W+1)'(NEAR_NINE_LSB) <
                         (INTEN_W+1)'(NINE_Q88)));
    end

    assign chain_valid[0] = s_tvalid;
    assign chain_item[0]  = entry;

    generate
        for (genvar g = 0; g <= MAX_VERTICES; g++)
        begin : g_cell
            prpf_cell #(
                .IDX          (g),
                .MAX_VERTICES (MAX_VERTICES),
                .CNT_W        (CNT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (advance),
                .in_valid  (chain_valid[g]),
                .in_item   (chain_item[g]),
                .n_used    (n_used),
                .out_valid (chain_valid[g+1]),
                .out_item  (chain_item[g+1])
            );
        end
    endgenerate

    // Tail: loads end here silently; points produce a result.
    item_t tail;
    logic  tail_point;
    logic  tail_inside;
    logic  tail_keep;

    assign tail        = chain_item[CHAIN-1];
    assign tail_point  = chain_valid[CHAIN-1] && (tail.func == FUNC_POINT);
    assign tail_inside = tail.zok && tail.parity;
    assign tail_keep   = (ko_reg ? !tail_inside : tail_inside) || tail.rescue;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_keep_reg;
    logic                      out_inside_reg;
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic signed [COORD_W-1:0] out_z_reg;
    logic [INTEN_W-1:0]        out_i_reg;

    // The chain moves unless a finished point would run into a held result.
    assign advance = !(tail_point && out_valid_reg && !m_tready);

    always_comb
    begin
        priority if (advance && tail_point)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_point)
        begin
            out_keep_reg   <= tail_keep;
            out_inside_reg <= tail_inside;
            out_x_reg      <= tail.px;
            out_y_reg      <= tail.py;
            out_z_reg      <= tail.pz;
            out_i_reg      <= tail.inten;
        end
    end

    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_inside_reg, out_keep_reg};
    assign m_tdata  = {out_i_reg, out_z_reg, out_y_reg, out_x_reg};

endmodule

// ===== sv/prpf_cell.sv =====
// One cell of the chain: holds at most one polygon vertex and tests at most one edge in three stages.
module prpf_cell #(
    parameter int IDX          = 0,
    parameter int MAX_VERTICES = prpf_pkg::MAX_VERTICES_DEF,
    parameter int CNT_W        = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  prpf_pkg::item_t in_item,
    input  logic [CNT_W-1:0] n_used,
    output logic            out_valid,
    output prpf_pkg::item_t out_item
);
    import prpf_pkg::*;

    localparam bit IS_CLOSE = (IDX == MAX_VERTICES);
    localparam bit WRITABLE = (IDX < MAX_VERTICES) && (IDX < 2 ** VIDX_W);

    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;

    // The closing cell uses vertex 0 as its far end. A slot that no load can
    // reach is never valid to read, so it simply mirrors vertex 0 as well.
    generate
        if (WRITABLE)
        begin : g_store
            logic signed [COORD_W-1:0] vx_reg;
            logic signed [COORD_W-1:0] vy_reg;

            always_ff @(posedge clk)
            begin
                if (en && in_valid && (in_item.func == FUNC_LOAD) &&
                    (in_item.vidx == VIDX_W'(IDX)))
                begin
                    vx_reg <= in_item.px;
                    vy_reg <= in_item.py;
                end
            end

            assign end_x = vx_reg;
            assign end_y = vy_reg;
        end
        else
        begin : g_nostore
            assign end_x = in_item.v0x;
            assign end_y = in_item.v0y;
        end
    endgenerate

    // Stage 1: pick the edge, form the differences.
    item_t                    s1_item_next;
    logic                     edge_on;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy_abs;
    logic signed [DIFF_W-1:0] dx_adj;
    logic signed [DIFF_W-1:0] la;
    logic signed [DIFF_W-1:0] ra;
    logic                     straddle;

    always_comb
    begin
        s1_item_next = in_item;
        edge_on      = 1'b0;
        if (in_item.func == FUNC_POINT)
        begin
            if (IS_CLOSE)
            begin
                edge_on = (n_used != '0);
            end
            else if (IDX == 0)
            begin
                s1_item_next.v0x   = end_x;
                s1_item_next.v0y   = end_y;
                s1_item_next.prevx = end_x;
                s1_item_next.prevy = end_y;
            end
            else if (CNT_W'(IDX) < n_used)
            begin
                edge_on            = 1'b1;
                s1_item_next.prevx = end_x;
                s1_item_next.prevy = end_y;
            end
        end
    end

    always_comb
    begin
        dy       = DIFF_W'(end_y) - DIFF_W'(in_item.prevy);
        dx       = DIFF_W'(end_x) - DIFF_W'(in_item.prevx);
        dy_abs   = dy[DIFF_W-1] ? -dy : dy;
        dx_adj   = dy[DIFF_W-1] ? -dx : dx;
        la       = DIFF_W'(in_item.px) - DIFF_W'(in_item.prevx);
        ra       = DIFF_W'(in_item.py) - DIFF_W'(in_item.prevy);
        straddle = edge_on &&
                   ((in_item.prevy <= in_item.py) != (end_y <= in_item.py));
    end

    logic                     s1_valid_reg;
    item_t                    s1_item_reg;
    logic                     s1_cross_reg;
    logic signed [DIFF_W-1:0] s1_la_reg;
    logic signed [DIFF_W-1:0] s1_lb_reg;
    logic signed [DIFF_W-1:0] s1_ra_reg;
    logic signed [DIFF_W-1:0] s1_rb_reg;

    // Stage 2: the two cross products.
    logic                     s2_valid_reg;
    item_t                    s2_item_reg;
    logic                     s2_cross_reg;
    logic signed [PROD_W-1:0] s2_lhs_reg;
    logic signed [PROD_W-1:0] s2_rhs_reg;

    // Stage 3: compare and fold into the parity.
    logic                     s3_valid_reg;
    item_t                    s3_item_reg;
    item_t                    s3_item_next;

    always_comb
    begin
        s3_item_next        = s2_item_reg;
        s3_item_next.parity = s2_item_reg.parity ^
                              (s2_cross_reg && (s2_lhs_reg < s2_rhs_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg  <= s1_item_next;
            s1_cross_reg <= straddle;
            s1_la_reg    <= la;
            s1_lb_reg    <= dy_abs;
            s1_ra_reg    <= ra;
            s1_rb_reg    <= dx_adj;

            s2_item_reg  <= s1_item_reg;
            s2_cross_reg <= s1_cross_reg;
            s2_lhs_reg   <= s1_la_reg * s1_lb_reg;
            s2_rhs_reg   <= s1_ra_reg * s1_rb_reg;

            s3_item_reg  <= s3_item_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

// ===== sv/prpf_checker.sv =====
// Port-level assertions for the polygon region point filter, bound to the top level.
module prpf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [prpf_pkg::OUT_TUSER_W-1:0] m_tuser,
    input logic                             cfg_wen,
    input logic [prpf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input logic [prpf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import prpf_pkg::*;

    // Shadow copies of the two registers that decide how keep relates to inside.
    logic ko_reg;
    logic ien_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ko_reg  <= 1'b0;
            ien_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            if (cfg_addr == REG_KEEP_OUTSIDE)
            begin
                ko_reg <= cfg_wdata[0];
            end
            if (cfg_addr == REG_INTENSITY_ENABLE)
            begin
                ien_reg <= cfg_wdata[0];
            end
        end
    end

    // Once reset has been seen at an edge, no result is shown on the next one.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // The chain may only stall when a held result blocks the output.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with a free output");

    // With no outside mode and no rescue, keep is exactly the inside flag.
    a_keep_is_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !ko_reg && !ien_reg) |-> (m_tuser[0] == m_tuser[1]))
        else $error("keep differs from inside with plain filtering");

    // A result that is not taken stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn before transfer");

    // An input is refused only while a result is offered.
    a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && !s_tready) |-> m_tvalid)
        else $error("input refused while output empty");

endmodule

bind polygon_region_point_filter prpf_checker u_prpf_checker (.*);

// ===== verif/polygon_region_point_filter_tb.sv =====
// Self-checking testbench for the polygon region point filter: directed and random streams.
module polygon_region_point_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import prpf_pkg::*;

    localparam int VERTS         = MAX_VERTICES_DEF;
    // Depth of the path from a point's transfer to the output register.
    localparam int PIPE_DEPTH    = 3 * (VERTS + 1) + 1;
    localparam int SETTLE_CYCLES = PIPE_DEPTH + 24;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int NINE_POINT_ZERO = 2304;
    localparam int NEAR_NINE_BAND  = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam logic signed [31:0] Z_LOWEST  = 32'sh8000_0000;
    localparam logic signed [31:0] Z_HIGHEST = 32'sh7FFF_FFFF;

    typedef struct {
        logic        keep;
        logic        in_poly;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] inten;
    } point_verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic s_tuser = 1'b0;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_wen = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the vertex store and the configuration.
    logic signed [31:0] vx_tab [VERTS];
    logic signed [31:0] vy_tab [VERTS];
    logic [6:0]         cnt_r      = 7'd0;
    logic signed [31:0] min_z_r    = Z_LOWEST;
    logic signed [31:0] max_z_r    = Z_HIGHEST;
    logic               inten_en_r = 1'b0;
    logic [15:0]        min_int_r  = 16'h0000;
    logic [15:0]        max_int_r  = 16'hFFFF;
    logic               outside_r  = 1'b0;

    point_verdict_t verdict_q [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 21;
    int sink_stall_pct = 64;

    polygon_region_point_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("polygon_region_point_filter_tb: errors");
        $finish;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [31:0] q16(input int v);
        return v <<< 16;
    endfunction

    // Crossing parity of a +X ray from (px,py), compared exactly by cross products.
    function automatic logic crosses_odd(input logic signed [31:0] px,
                                         input logic signed [31:0] py);
        int n;
        int j;
        int crossings;
        logic signed [32:0] pxe, pye, x1, y1, x2, y2, dx, dy;
        logic signed [65:0] lhs, rhs;
        n = (cnt_r > VERTS) ? VERTS : int'(cnt_r);
        crossings = 0;
        pxe = px;
        pye = py;
        for (int i = 0; i < n; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            x1 = vx_tab[i];
            y1 = vy_tab[i];
            x2 = vx_tab[j];
            y2 = vy_tab[j];
            if ((y1 <= pye) != (y2 <= pye))
            begin
                dy = y2 - y1;
                dx = x2 - x1;
                if (dy < 0)
                begin
                    dy = -dy;
                    dx = -dx;
                end
                lhs = (pxe - x1) * dy;
                rhs = (pye - y1) * dx;
                if (lhs < rhs)
                    crossings++;
            end
        end
        return crossings[0];
    endfunction

    function automatic point_verdict_t judge_point(input logic signed [31:0] px,
                                                   input logic signed [31:0] py,
                                                   input logic signed [31:0] pz,
                                                   input logic [15:0] it);
        point_verdict_t v;
        logic primary;
        logic rescue;
        v.in_poly = 1'b0;
        if (pz >= min_z_r && pz <= max_z_r)
            v.in_poly = crosses_odd(px, py);
        primary = outside_r ? !v.in_poly : v.in_poly;
        rescue = inten_en_r && it >= min_int_r && it <= max_int_r &&
                 (int'(it) > NINE_POINT_ZERO + NEAR_NINE_BAND ||
                  int'(it) + NEAR_NINE_BAND < NINE_POINT_ZERO);
        v.keep  = primary || rescue;
        v.x     = px;
        v.y     = py;
        v.z     = pz;
        v.inten = it;
        return v;
    endfunction

    // Offers one item until it transfers, then updates the shadow state.
    task automatic send_item(input func_t f, input logic [5:0] idx,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [15:0] it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {2'b00, it, z, y, x, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (f == FUNC_POINT)
            verdict_q.insert(verdict_q.size(), judge_point(x, y, z, it));
        else
        begin
            vx_tab[idx] = x;
            vy_tab[idx] = y;
        end
    endtask

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [15:0] it);
        send_item(FUNC_POINT, 6'($urandom), x, y, z, it);
    endtask

    task automatic send_load(input logic [5:0] idx, input logic [31:0] x,
                             input logic [31:0] y);
        send_item(FUNC_LOAD, idx, x, y, $urandom, 16'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
    endtask

    // Loads give no result, so the chain is given a full pass before any write.
    task automatic settle_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        unique case (addr)
            REG_VERTEX_COUNT:     cnt_r      = data[6:0];
            REG_MIN_Z:            min_z_r    = data;
            REG_MAX_Z:            max_z_r    = data;
            REG_INTENSITY_ENABLE: inten_en_r = data[0];
            REG_MIN_INTENSITY:    min_int_r  = data[15:0];
            REG_MAX_INTENSITY:    max_int_r  = data[15:0];
            REG_KEEP_OUTSIDE:     outside_r  = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Keeps the field in the low bits and fills the rest of the write data at random.
    function automatic logic [31:0] pad_upper(input logic [31:0] v, input int w);
        logic [31:0] m;
        m = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
        return (v & m) | ($urandom & ~m);
    endfunction

    function automatic logic [31:0] box_coord(input int half);
        if (half == 0)
            return $urandom;
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        point_verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t ns: result with none expected, expected none actual %h_%h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                report_field("keep", 32'(want.keep), 32'(m_tuser[0]));
                report_field("inside_res", 32'(want.in_poly), 32'(m_tuser[1]));
                report_field("out_x", want.x, m_tdata[31:0]);
                report_field("out_y", want.y, m_tdata[63:32]);
                report_field("out_z", want.z, m_tdata[95:64]);
                report_field("out_intensity", 32'(want.inten), 32'(m_tdata[111:96]));
            end
        end
    end

    // Reset values: no vertices in use, so nothing is inside.
    task automatic test_empty_polygon();
        send_point(32'd0, 32'd0, 32'd0, 16'd0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    endtask

    task automatic test_square_window();
        send_load(6'd0, q16(-10), q16(-10));
        send_load(6'd1, q16(10), q16(-10));
        send_load(6'd2, q16(10), q16(10));
        send_load(6'd3, q16(-10), q16(10));
        settle_idle();
        cfg_write(REG_VERTEX_COUNT, 32'd4);
        send_point(q16(0), q16(0), 32'd0, 16'd0);
        send_point(q16(20), q16(0), 32'd0, 16'd0);
        send_point(q16(10), q16(0), 32'd0, 16'd0);
        // Level with the bottom edge, which is horizontal.
        send_point(q16(0), q16(-10), 32'd0, 16'd0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 16'd0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'd0, 16'd0);
        settle_idle();
        cfg_write(REG_MIN_Z, q16(-5));
        cfg_write(REG_MAX_Z, q16(5));
        // Both bounds of the height window are part of it.
        send_point(q16(0), q16(0), q16(-5), 16'd0);
        send_point(q16(0), q16(0), q16(5), 16'd0);
        send_point(q16(0), q16(0), q16(5) + 32'd1, 16'd0);
        send_point(q16(0), q16(0), q16(-5) - 32'd1, 16'd0);
    endtask

    task automatic test_intensity_rescue();
        settle_idle();
        cfg_write(REG_INTENSITY_ENABLE, 32'd1);
        cfg_write(REG_MIN_INTENSITY, 32'h0100);
        cfg_write(REG_MAX_INTENSITY, 32'hF000);
        // Outside points, so only the rescue can keep them; 2304 is 9.0.
        send_point(q16(20), q16(0), 32'd0, 16'd2304);
        send_point(q16(20), q16(0), 32'd0, 16'd2306);
        send_point(q16(20), q16(0), 32'd0, 16'd2307);
        send_point(q16(20), q16(0), 32'd0, 16'd2301);
        send_point(q16(20), q16(0), 32'd0, 16'h00FF);
        send_point(q16(20), q16(0), 32'd0, 16'hF000);
        settle_idle();
        cfg_write(REG_KEEP_OUTSIDE, 32'd1);
        send_point(q16(0), q16(0), 32'd0, 16'd2304);
        send_point(q16(20), q16(0), 32'd0, 16'd2304);
    endtask

    task automatic test_degenerate_shapes();
        send_load(6'd1, q16(10), q16(10));
        settle_idle();
        cfg_write(REG_KEEP_OUTSIDE, 32'd0);
        cfg_write(REG_INTENSITY_ENABLE, 32'd0);
        cfg_write(REG_VERTEX_COUNT, 32'd1);
        send_point(q16(-20), q16(-10), 32'd0, 16'd0);
        settle_idle();
        // Two vertices: the edge and its return cross together.
        cfg_write(REG_VERTEX_COUNT, 32'd2);
        send_point(q16(-20), q16(0), 32'd0, 16'd0);
        send_point(q16(0), q16(0), 32'd0, 16'd0);
        settle_idle();
        cfg_write(REG_VERTEX_COUNT, 32'd3);
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_point(q16(5), q16(0), 32'd0, 16'd0);
        send_point(q16(-5), q16(0), 32'd0, 16'd0);
    endtask

    // One random phase: a fresh load of all 64 vertices, a register setting, then points.
    task automatic test_random_traffic(input int phase, input int n_points);
        int half;
        int pts;
        int r;
        logic [6:0] cnt;
        logic signed [31:0] zlo, zhi, a, b;
        logic ien, outs;
        logic [15:0] ilo, ihi, it;
        logic [31:0] x, y, z;
        longint span;
        longint unsigned roll;
        unique case (phase % 3)
            0: half = 1 << 12;
            1: half = 1 << 22;
            default: half = 0;
        endcase
        unique case (phase / 3)
            0:
            begin
                src_idle_pct = 21;
                sink_stall_pct = 64;
            end
            1:
            begin
                src_idle_pct = 64;
                sink_stall_pct = 21;
            end
            default:
            begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
        endcase
        for (int i = 0; i < VERTS; i++)
            send_load(6'(i), box_coord(half), box_coord(half));
        settle_idle();
        unique case (phase)
            0:
            begin
                cnt = 7'd64; zlo = Z_LOWEST; zhi = Z_HIGHEST;
                ien = 1'b0; ilo = 16'h0000; ihi = 16'hFFFF; outs = 1'b0;
            end
            1:
            begin
                // Above the table size the count saturates.
                cnt = 7'd127; zlo = Z_LOWEST; zhi = Z_HIGHEST;
                ien = 1'b1; ilo = 16'h0000; ihi = 16'hFFFF; outs = 1'b1;
            end
            2:
            begin
                // An inverted height window admits nothing.
                cnt = 7'd3; zlo = $urandom_range(1, 1000); zhi = -zlo;
                ien = 1'b1; ilo = 16'($urandom); ihi = ilo; outs = 1'b0;
            end
            default:
            begin
                r = $urandom_range(9);
                if (r == 0)
                    cnt = 7'($urandom_range(65, 127));
                else if (r == 1)
                    cnt = 7'd64;
                else if (r == 2)
                    cnt = 7'($urandom_range(0, 2));
                else
                    cnt = 7'($urandom_range(3, 16));
                a = $urandom;
                b = $urandom;
                zlo = (a < b) ? a : b;
                zhi = (a < b) ? b : a;
                if ($urandom_range(5) == 0)
                begin
                    zlo = zhi;
                    zhi = (a < b) ? a : b;
                end
                ien = 1'($urandom);
                ilo = 16'($urandom);
                ihi = 16'($urandom);
                if (ilo > ihi && $urandom_range(3) != 0)
                begin
                    it = ilo;
                    ilo = ihi;
                    ihi = it;
                end
                outs = 1'($urandom);
            end
        endcase
        cfg_write(REG_VERTEX_COUNT, pad_upper(32'(cnt), 7));
        cfg_write(REG_MIN_Z, zlo);
        cfg_write(REG_MAX_Z, zhi);
        cfg_write(REG_INTENSITY_ENABLE, pad_upper(32'(ien), 1));
        cfg_write(REG_MIN_INTENSITY, pad_upper(32'(ilo), 16));
        cfg_write(REG_MAX_INTENSITY, pad_upper(32'(ihi), 16));
        cfg_write(REG_KEEP_OUTSIDE, pad_upper(32'(outs), 1));
        if (phase == 4)
            cfg_write(REG_UNUSED, $urandom);
        pts = 0;
        while (pts < n_points)
        begin
            if (pts == n_points / 2)
                wait_drained();
            if ($urandom_range(15) == 0)
            begin
                // A vertex moves while points are in flight.
                send_load(6'($urandom), box_coord(half), box_coord(half));
                continue;
            end
            r = $urandom_range(9);
            if (r == 0)
            begin
                x = $urandom;
                y = $urandom;
            end
            else if (r == 1)
            begin
                x = box_coord(half);
                y = vy_tab[$urandom_range(VERTS - 1)];
            end
            else if (r == 2)
            begin
                r = $urandom_range(VERTS - 1);
                x = vx_tab[r];
                y = vy_tab[r];
            end
            else
            begin
                x = box_coord(half);
                y = box_coord(half);
            end
            r = $urandom_range(7);
            span = longint'(max_z_r) - longint'(min_z_r) + 1;
            if (r == 0)
                z = min_z_r;
            else if (r == 1)
                z = max_z_r;
            else if (r == 2 || span <= 0)
                z = $urandom;
            else
            begin
                roll = {$urandom, $urandom};
                z = 32'(longint'(min_z_r) + longint'(roll % longint'(span)));
            end
            r = $urandom_range(9);
            unique case (r)
                0: it = 16'(NINE_POINT_ZERO - 3 + $urandom_range(0, 6));
                1: it = min_int_r;
                2: it = max_int_r;
                3: it = min_int_r - 16'd1;
                4: it = max_int_r + 16'd1;
                default: it = 16'($urandom);
            endcase
            send_point(x, y, z, it);
            pts++;
        end
    endtask

    initial
    begin
        for (int i = 0; i < VERTS; i++)
        begin
            vx_tab[i] = '0;
            vy_tab[i] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_polygon();
        test_square_window();
        test_intensity_rescue();
        test_degenerate_shapes();
        for (int k = 0; k < 9; k++)
        begin
            settle_idle();
            test_random_traffic(k, 78);
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && verdict_q.size() == 0)
            $display("polygon_region_point_filter_tb: clean");
        else
            $display("polygon_region_point_filter_tb: errors");
        $finish;
    end

endmodule
